/* rtl/core/blc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package blc_pkg;

  // Field widths of the line rasterizer.
  localparam int CoordBits = 16;
  localparam int ColorBits = 24;
  localparam int DimBits   = 13;
  localparam int IndexBits = 24;
  localparam int SpanBits  = CoordBits + 1;
  localparam int ErrBits   = CoordBits + 3;
  localparam int StepBits  = 2;
  localparam int CmpBits   = (CoordBits > DimBits) ? CoordBits + 1 : DimBits + 1;

  // Configuration port.
  localparam int CfgIdxBits = 1;

  // Frame size after reset.
  localparam logic [DimBits-1:0] FrameWidthRst  = DimBits'(2000);
  localparam logic [DimBits-1:0] FrameHeightRst = DimBits'(1500);

  // Command queue between the front and the back.
  localparam int FifoDepth = 2;
  localparam int PtrBits   = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int CntBits   = $clog2(FifoDepth + 1);

  typedef enum logic {
    FuncStart = 1'b0,
    FuncStep  = 1'b1
  } func_e;

  typedef enum logic [CfgIdxBits-1:0] {
    RegFrameWidth  = 1'b0,
    RegFrameHeight = 1'b1
  } reg_e;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [StepBits-1:0]  step_t;
  typedef logic [SpanBits-1:0]         span_t;
  typedef logic signed [ErrBits-1:0]   err_t;
  typedef logic [ColorBits-1:0]        color_t;
  typedef logic [DimBits-1:0]          dim_t;

  localparam step_t StepZero = 2'sb00;
  localparam step_t StepPos  = 2'sb01;
  localparam step_t StepNeg  = 2'sb11;

  // One classified command as it travels through the queue.
  typedef struct packed {
    logic   is_start;
    coord_t cur_x;
    coord_t cur_y;
    coord_t tgt_x;
    coord_t tgt_y;
    step_t  step_x;
    step_t  step_y;
    span_t  span_x;
    span_t  span_y;
    logic   x_major;
    color_t color;
    logic   run;
  } cmd_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

/* rtl/core/blc_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Input items: start or step commands.
interface blc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic signed [blc_pkg::CoordBits-1:0] start_x;
  logic signed [blc_pkg::CoordBits-1:0] start_y;
  logic signed [blc_pkg::CoordBits-1:0] end_x;
  logic signed [blc_pkg::CoordBits-1:0] end_y;
  logic [blc_pkg::ColorBits-1:0] line_color;

  modport source (output valid, func, start_x, start_y, end_x, end_y, line_color,
                  input ready);
  modport sink (input valid, func, start_x, start_y, end_x, end_y, line_color,
                output ready);
endinterface

// Result items: one pixel or an empty result.
interface blc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          pixel_valid;
  logic signed [blc_pkg::CoordBits-1:0] pixel_x;
  logic signed [blc_pkg::CoordBits-1:0] pixel_y;
  logic                          in_frame;
  logic [blc_pkg::IndexBits-1:0] pixel_index;
  logic [blc_pkg::ColorBits-1:0] pixel_color;
  logic                          last;

  modport source (output valid, pixel_valid, pixel_x, pixel_y, in_frame, pixel_index,
                  pixel_color, last, input ready);
  modport sink (input valid, pixel_valid, pixel_x, pixel_y, in_frame, pixel_index,
                pixel_color, last, output ready);
endinterface

// Register writes.
interface blc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [blc_pkg::CfgIdxBits-1:0] index;
  logic [blc_pkg::DimBits-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/blc_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module blc_front (
  blc_in_if.sink              in_i,
  input  blc_pkg::fifo_stat_t stat_i,
  output logic                push_o,
  output blc_pkg::cmd_t       cmd_o
);

  logic signed [blc_pkg::SpanBits-1:0] dx;
  logic signed [blc_pkg::SpanBits-1:0] dy;
  blc_pkg::span_t                      span_x;
  blc_pkg::span_t                      span_y;

  // Accept whenever the queue has room.
  assign in_i.ready = !stat_i.full;
  assign push_o     = in_i.valid && !stat_i.full;

  // Signed deltas between the endpoints.
  assign dx = blc_pkg::SpanBits'(in_i.end_x) - blc_pkg::SpanBits'(in_i.start_x);
  assign dy = blc_pkg::SpanBits'(in_i.end_y) - blc_pkg::SpanBits'(in_i.start_y);

  assign span_x = dx[blc_pkg::SpanBits-1] ? blc_pkg::span_t'(-dx) : blc_pkg::span_t'(dx);
  assign span_y = dy[blc_pkg::SpanBits-1] ? blc_pkg::span_t'(-dy) : blc_pkg::span_t'(dy);

  // Classify the item and precompute the walk setup for a start.
  always_comb begin
    cmd_o.is_start = (in_i.func == blc_pkg::FuncStart);
    cmd_o.cur_x    = in_i.start_x;
    cmd_o.cur_y    = in_i.start_y;
    cmd_o.tgt_x    = in_i.end_x;
    cmd_o.tgt_y    = in_i.end_y;
    cmd_o.span_x   = span_x;
    cmd_o.span_y   = span_y;
    cmd_o.x_major  = (span_x >= span_y);
    cmd_o.color    = in_i.line_color;
    cmd_o.run      = (dx != '0) || (dy != '0);
    if (dx == '0) begin
      cmd_o.step_x = blc_pkg::StepZero;
    end else if (dx[blc_pkg::SpanBits-1]) begin
      cmd_o.step_x = blc_pkg::StepNeg;
    end else begin
      cmd_o.step_x = blc_pkg::StepPos;
    end
    if (dy == '0) begin
      cmd_o.step_y = blc_pkg::StepZero;
    end else if (dy[blc_pkg::SpanBits-1]) begin
      cmd_o.step_y = blc_pkg::StepNeg;
    end else begin
      cmd_o.step_y = blc_pkg::StepPos;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/blc_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module blc_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  blc_pkg::cmd_t       cmd_i,
  input  logic                pop_i,
  output blc_pkg::cmd_t       cmd_o,
  output blc_pkg::fifo_stat_t stat_o
);

  blc_pkg::cmd_t                  mem_q [blc_pkg::FifoDepth];
  logic [blc_pkg::PtrBits-1:0]    wr_ptr_q, wr_ptr_d;
  logic [blc_pkg::PtrBits-1:0]    rd_ptr_q, rd_ptr_d;
  logic [blc_pkg::CntBits-1:0]    count_q, count_d;
  logic                           do_push;
  logic                           do_pop;

  assign stat_o.full  = (count_q == blc_pkg::CntBits'(blc_pkg::FifoDepth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign cmd_o        = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == blc_pkg::PtrBits'(blc_pkg::FifoDepth - 1)) ? '0 :
                 wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == blc_pkg::PtrBits'(blc_pkg::FifoDepth - 1)) ? '0 :
                 rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= blc_pkg::CntBits'(blc_pkg::FifoDepth))
    else $error("command queue overfilled");

  // The back never pops an empty queue.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("pop from empty command queue");

endmodule

`default_nettype wire

/* rtl/core/blc_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module blc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  blc_pkg::cmd_t       cmd_i,
  input  blc_pkg::fifo_stat_t stat_i,
  output logic                pop_o,
  input  blc_pkg::dim_t       frame_width_i,
  input  blc_pkg::dim_t       frame_height_i,
  blc_out_if.source           out_o
);

  // Walk state.
  blc_pkg::coord_t cur_x_q, cur_x_d;
  blc_pkg::coord_t cur_y_q, cur_y_d;
  blc_pkg::coord_t tgt_x_q, tgt_x_d;
  blc_pkg::coord_t tgt_y_q, tgt_y_d;
  blc_pkg::step_t  step_x_q, step_x_d;
  blc_pkg::step_t  step_y_q, step_y_d;
  blc_pkg::span_t  span_x_q, span_x_d;
  blc_pkg::span_t  span_y_q, span_y_d;
  blc_pkg::err_t   err_q, err_d;
  logic            x_major_q, x_major_d;
  blc_pkg::color_t color_q, color_d;
  logic            running_q, running_d;

  // Walk stage result.
  logic            s1_v_q;
  logic            s1_pix_q, s1_pix_d;
  blc_pkg::coord_t s1_x_q, s1_x_d;
  blc_pkg::coord_t s1_y_q, s1_y_d;
  logic            s1_last_q, s1_last_d;
  blc_pkg::color_t s1_color_q, s1_color_d;

  // Output register.
  logic                          out_v_q;
  logic                          out_pix_q;
  blc_pkg::coord_t               out_x_q, out_y_q;
  logic                          out_in_frame_q, out_in_frame_d;
  logic [blc_pkg::IndexBits-1:0] out_index_q, out_index_d;
  blc_pkg::color_t               out_color_q;
  logic                          out_last_q;

  logic                          out_adv;
  logic                          s1_adv;
  logic                          at_end;
  blc_pkg::span_t                minor_span;
  blc_pkg::span_t                major_span;
  blc_pkg::err_t                 err_sum;
  logic signed [blc_pkg::ErrBits:0] err_twice;
  logic                          minor_step;
  logic [blc_pkg::CmpBits-1:0]   ux, uy, uw, uh;
  logic [blc_pkg::IndexBits-1:0] ix, iy, iw;

  // Pipeline flow: each stage moves when the one after it has room.
  assign out_adv = !out_v_q || out_o.ready;
  assign s1_adv  = !s1_v_q || out_adv;
  assign pop_o   = !stat_i.empty && s1_adv;

  // Error term arithmetic for one step along the major axis.
  assign at_end     = x_major_q ? (cur_x_q == tgt_x_q) : (cur_y_q == tgt_y_q);
  assign minor_span = x_major_q ? span_y_q : span_x_q;
  assign major_span = x_major_q ? span_x_q : span_y_q;
  assign err_sum    = err_q + $signed(blc_pkg::ErrBits'(minor_span));
  assign err_twice  = {err_sum, 1'b0};
  assign minor_step = err_twice >= $signed((blc_pkg::ErrBits + 1)'(major_span));

  // Walk: load a new line or produce the next pixel; a start, or a step with no line running, gives an empty result.
  always_comb begin
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    tgt_x_d    = tgt_x_q;
    tgt_y_d    = tgt_y_q;
    step_x_d   = step_x_q;
    step_y_d   = step_y_q;
    span_x_d   = span_x_q;
    span_y_d   = span_y_q;
    err_d      = err_q;
    x_major_d  = x_major_q;
    color_d    = color_q;
    running_d  = running_q;
    s1_pix_d   = 1'b0;
    s1_x_d     = '0;
    s1_y_d     = '0;
    s1_last_d  = 1'b0;
    s1_color_d = '0;
    if (cmd_i.is_start) begin
      cur_x_d   = cmd_i.cur_x;
      cur_y_d   = cmd_i.cur_y;
      tgt_x_d   = cmd_i.tgt_x;
      tgt_y_d   = cmd_i.tgt_y;
      step_x_d  = cmd_i.step_x;
      step_y_d  = cmd_i.step_y;
      span_x_d  = cmd_i.span_x;
      span_y_d  = cmd_i.span_y;
      err_d     = '0;
      x_major_d = cmd_i.x_major;
      color_d   = cmd_i.color;
      running_d = cmd_i.run;
    end else if (running_q) begin
      s1_pix_d   = 1'b1;
      s1_color_d = color_q;
      if (at_end) begin
        s1_x_d    = tgt_x_q;
        s1_y_d    = tgt_y_q;
        s1_last_d = 1'b1;
        running_d = 1'b0;
      end else begin
        s1_x_d = cur_x_q;
        s1_y_d = cur_y_q;
        err_d  = minor_step ? err_sum - $signed(blc_pkg::ErrBits'(major_span)) : err_sum;
        if (x_major_q) begin
          cur_x_d = cur_x_q + blc_pkg::CoordBits'(step_x_q);
          if (minor_step) begin
            cur_y_d = cur_y_q + blc_pkg::CoordBits'(step_y_q);
          end
        end else begin
          cur_y_d = cur_y_q + blc_pkg::CoordBits'(step_y_q);
          if (minor_step) begin
            cur_x_d = cur_x_q + blc_pkg::CoordBits'(step_x_q);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      tgt_x_q   <= '0;
      tgt_y_q   <= '0;
      step_x_q  <= blc_pkg::StepZero;
      step_y_q  <= blc_pkg::StepZero;
      span_x_q  <= '0;
      span_y_q  <= '0;
      err_q     <= '0;
      x_major_q <= 1'b0;
      color_q   <= '0;
      running_q <= 1'b0;
    end else if (pop_o) begin
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      tgt_x_q   <= tgt_x_d;
      tgt_y_q   <= tgt_y_d;
      step_x_q  <= step_x_d;
      step_y_q  <= step_y_d;
      span_x_q  <= span_x_d;
      span_y_q  <= span_y_d;
      err_q     <= err_d;
      x_major_q <= x_major_d;
      color_q   <= color_d;
      running_q <= running_d;
    end
  end

  // Walk stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_adv) begin
      s1_v_q <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_pix_q   <= s1_pix_d;
      s1_x_q     <= s1_x_d;
      s1_y_q     <= s1_y_d;
      s1_last_q  <= s1_last_d;
      s1_color_q <= s1_color_d;
    end
  end

  // Clipping and frame-buffer index.
  assign ux = blc_pkg::CmpBits'($unsigned(s1_x_q));
  assign uy = blc_pkg::CmpBits'($unsigned(s1_y_q));
  assign uw = blc_pkg::CmpBits'(frame_width_i);
  assign uh = blc_pkg::CmpBits'(frame_height_i);
  assign ix = blc_pkg::IndexBits'($unsigned(s1_x_q));
  assign iy = blc_pkg::IndexBits'($unsigned(s1_y_q));
  assign iw = blc_pkg::IndexBits'(frame_width_i);

  always_comb begin
    out_in_frame_d = s1_pix_q && !s1_x_q[blc_pkg::CoordBits-1] &&
                     !s1_y_q[blc_pkg::CoordBits-1] && (ux < uw) && (uy < uh);
    out_index_d    = out_in_frame_d ? (iy * iw + ix) : '0;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_adv) begin
      out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_v_q) begin
      out_pix_q      <= s1_pix_q;
      out_x_q        <= s1_x_q;
      out_y_q        <= s1_y_q;
      out_in_frame_q <= out_in_frame_d;
      out_index_q    <= out_index_d;
      out_color_q    <= s1_color_q;
      out_last_q     <= s1_last_q;
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.pixel_valid = out_pix_q;
  assign out_o.pixel_x     = out_x_q;
  assign out_o.pixel_y     = out_y_q;
  assign out_o.in_frame    = out_in_frame_q;
  assign out_o.pixel_index = out_index_q;
  assign out_o.pixel_color = out_color_q;
  assign out_o.last        = out_last_q;

  // An empty result carries all-zero fields.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.pixel_valid) |->
      (out_o.pixel_x == '0 && out_o.pixel_y == '0 && out_o.pixel_color == '0 &&
       !out_o.last && !out_o.in_frame))
    else $error("empty result with nonzero fields");

  // A clipped pixel never carries an index.
  a_clip_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.in_frame) |-> (out_o.pixel_index == '0))
    else $error("index on a clipped pixel");

  // The end pixel closes the line.
  a_end_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && !cmd_i.is_start && running_q && at_end) |=> (!running_q && s1_last_q))
    else $error("line still active after its end pixel");

endmodule

`default_nettype wire

/* rtl/core/bresenham_line_clipped_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// An accepted item passes through the command queue, the walk stage register and the output register.
// Throughput: one item per cycle while the output is not stalled, set by the walk update in the back end.
// A two-entry command queue lets the input side keep accepting while the output stalls.
// Reset (asynchronous, active low) empties the pipeline, stops any line in progress and
// sets the frame to 2000 by 1500 pixels; no clearing pass is needed.

module bresenham_line_clipped_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  blc_in_if.sink     in_i,
  blc_out_if.source  out_o,
  blc_cfg_if.sink    cfg_i
);

  blc_pkg::dim_t       frame_width_q;
  blc_pkg::dim_t       frame_height_q;
  blc_pkg::cmd_t       front_cmd;
  blc_pkg::cmd_t       head_cmd;
  blc_pkg::fifo_stat_t fifo_stat;
  logic                push;
  logic                pop;

  // Frame registers; writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= blc_pkg::FrameWidthRst;
      frame_height_q <= blc_pkg::FrameHeightRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        blc_pkg::RegFrameWidth:  frame_width_q  <= cfg_i.data;
        blc_pkg::RegFrameHeight: frame_height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Front end: accept and classify items.
  blc_front u_front (
    .in_i   (in_i),
    .stat_i (fifo_stat),
    .push_o (push),
    .cmd_o  (front_cmd)
  );

  // Command queue.
  blc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (fifo_stat)
  );

  // Back end: line walk, clipping and result register.
  blc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (head_cmd),
    .stat_i         (fifo_stat),
    .pop_o          (pop),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .out_o          (out_o)
  );

endmodule

`default_nettype wire

/* verif/tb_bresenham_line_clipped_unit.sv */
`timescale 1ns / 1ps

module tb_bresenham_line_clipped_unit;
  import blc_pkg::*;

  localparam int   ClkHalf       = 4;
  localparam int   ResetCycles   = 11;
  localparam int   IdleMax       = 14;
  localparam int   WatchdogLimit = 1000;
  localparam int   RandomItems   = 450;
  localparam int   BatchItems    = 90;
  localparam int   SettleCycles  = 6;
  localparam int   FullSpanSteps = 16;
  localparam dim_t DimMax        = '1;

  // One pixel result as seen on the output channel.
  typedef struct packed {
    logic                 pixel_valid;
    coord_t               pixel_x;
    coord_t               pixel_y;
    logic                 in_frame;
    logic [IndexBits-1:0] pixel_index;
    color_t               pixel_color;
    logic                 last;
  } pixel_t;

  logic clk;
  logic rst_n;

  blc_in_if  cmd_if ();
  blc_out_if pix_if ();
  blc_cfg_if cfg_if ();

  bresenham_line_clipped_unit i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cmd_if),
    .out_o  (pix_if),
    .cfg_i  (cfg_if)
  );

  // Frame size and line walk as the block should hold them.
  dim_t   fb_width;
  dim_t   fb_height;
  coord_t walk_x;
  coord_t walk_y;
  coord_t goal_x;
  coord_t goal_y;
  step_t  dir_x;
  step_t  dir_y;
  span_t  dist_x;
  span_t  dist_y;
  err_t   err_sum;
  logic   along_x;
  color_t ink;
  logic   drawing;

  pixel_t expected_pixels[$];

  int  commands_sent = 0;
  int  pixels_seen   = 0;
  int  cfg_writes    = 0;
  int  mismatches    = 0;
  // When set, the sender or the receiver runs without idle cycles.
  bit  feed_calm     = 1'b0;
  bit  drain_calm    = 1'b0;

  // Free-running clock.
  always begin
    clk = 1'b0;
    #(ClkHalf);
    clk = 1'b1;
    #(ClkHalf);
  end

  function automatic int idle_cycles(bit calm);
    return calm ? 0 : int'($urandom_range(0, IdleMax));
  endfunction

  function automatic step_t direction_of(int delta);
    if (delta > 0) return StepPos;
    if (delta < 0) return StepNeg;
    return StepZero;
  endfunction

  // Build a pixel result, clipped against the current frame.
  function automatic pixel_t plot(coord_t x, coord_t y, logic is_last);
    pixel_t px;
    longint offset;
    px             = '0;
    px.pixel_valid = 1'b1;
    px.pixel_x     = x;
    px.pixel_y     = y;
    px.in_frame    = (x >= 0) && (y >= 0) &&
                     (int'(x) < int'(fb_width)) && (int'(y) < int'(fb_height));
    offset         = longint'(y) * longint'(fb_width) + longint'(x);
    if (px.in_frame) begin
      px.pixel_index = offset[IndexBits-1:0];
    end
    px.pixel_color = ink;
    px.last        = is_last;
    return px;
  endfunction

  // Apply one command to the line walk and return the result it produces.
  function automatic pixel_t advance_line(func_e func, coord_t x0, coord_t y0,
                                          coord_t x1, coord_t y1, color_t color);
    pixel_t px;
    int     dx;
    int     dy;
    int     acc;
    px = '0;
    if (func == FuncStart) begin
      dx      = int'(x1) - int'(x0);
      dy      = int'(y1) - int'(y0);
      walk_x  = x0;
      walk_y  = y0;
      goal_x  = x1;
      goal_y  = y1;
      dir_x   = direction_of(dx);
      dir_y   = direction_of(dy);
      dist_x  = span_t'((dx < 0) ? -dx : dx);
      dist_y  = span_t'((dy < 0) ? -dy : dy);
      err_sum = '0;
      along_x = dist_x >= dist_y;
      ink     = color;
      drawing = (dx != 0) || (dy != 0);
    end else if (drawing) begin
      if (along_x ? (walk_x == goal_x) : (walk_y == goal_y)) begin
        // The major axis has reached the target: emit the end point.
        px      = plot(goal_x, goal_y, 1'b1);
        drawing = 1'b0;
      end else begin
        px = plot(walk_x, walk_y, 1'b0);
        if (along_x) begin
          acc = int'(err_sum) + int'(dist_y);
          if (2 * acc >= int'(dist_x)) begin
            walk_y = coord_t'(int'(walk_y) + int'(dir_y));
            acc    = acc - int'(dist_x);
          end
          walk_x = coord_t'(int'(walk_x) + int'(dir_x));
        end else begin
          acc = int'(err_sum) + int'(dist_x);
          if (2 * acc >= int'(dist_y)) begin
            walk_x = coord_t'(int'(walk_x) + int'(dir_x));
            acc    = acc - int'(dist_y);
          end
          walk_y = coord_t'(int'(walk_y) + int'(dir_y));
        end
        err_sum = err_t'(acc);
      end
    end
    return px;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  // Compare one output transaction with the oldest expected pixel.
  function automatic void check_pixel(pixel_t got);
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      mismatches++;
      $display("%0t: no result expected, got 0x%0h", $time, got);
      return;
    end
    want = expected_pixels.pop_front();
    if (want.pixel_valid) begin
      pixels_seen++;
    end
    compare_field("pixel_valid", 32'(want.pixel_valid), 32'(got.pixel_valid));
    compare_field("pixel_x", 32'(want.pixel_x), 32'(got.pixel_x));
    compare_field("pixel_y", 32'(want.pixel_y), 32'(got.pixel_y));
    compare_field("in_frame", 32'(want.in_frame), 32'(got.in_frame));
    compare_field("pixel_index", 32'(want.pixel_index), 32'(got.pixel_index));
    compare_field("pixel_color", 32'(want.pixel_color), 32'(got.pixel_color));
    compare_field("last", 32'(want.last), 32'(got.last));
  endfunction

  // Send one command transaction; valid stays high when the next one follows at once.
  task automatic send_command(func_e func, coord_t x0, coord_t y0, coord_t x1, coord_t y1,
                              color_t color);
    int gap;
    gap = idle_cycles(feed_calm);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.func       <= func;
    cmd_if.start_x    <= x0;
    cmd_if.start_y    <= y0;
    cmd_if.end_x      <= x1;
    cmd_if.end_y      <= y1;
    cmd_if.line_color <= color;
    do @(posedge clk); while (!cmd_if.ready);
    expected_pixels.push_back(advance_line(func, x0, y0, x1, y1, color));
    commands_sent++;
  endtask

  // Step command; the endpoint and color fields carry noise.
  task automatic step_line();
    send_command(FuncStep, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                 coord_t'($urandom), color_t'($urandom));
  endtask

  // Start a line, walk it to its end and optionally step past the end.
  task automatic draw_line(int x0, int y0, int x1, int y1, color_t color, int extra);
    int ax;
    int ay;
    int steps;
    ax    = (x1 > x0) ? x1 - x0 : x0 - x1;
    ay    = (y1 > y0) ? y1 - y0 : y0 - y1;
    steps = ((ax > ay) ? ax : ay);
    if (steps > 0) begin
      steps++;
    end
    send_command(FuncStart, coord_t'(x0), coord_t'(y0), coord_t'(x1), coord_t'(y1), color);
    repeat (steps + extra) step_line();
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic drain_pipeline();
    cmd_if.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_frame_reg(reg_e idx, dim_t value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == RegFrameWidth) begin
      fb_width = value;
    end else begin
      fb_height = value;
    end
    cfg_writes++;
  endtask

  task automatic set_frame(dim_t width, dim_t height);
    drain_pipeline();
    write_frame_reg(RegFrameWidth, width);
    write_frame_reg(RegFrameHeight, height);
    cfg_if.valid <= 1'b0;
  endtask

  // Steps with no line active and a zero-length line give empty results.
  task automatic test_steps_without_line();
    step_line();
    step_line();
    draw_line(7, 7, 7, 7, 24'h123456, 1);
  endtask

  // Shallow, steep, horizontal and diagonal lines in several directions.
  task automatic test_line_directions();
    draw_line(0, 0, 3, 1, 24'hFFFFFF, 1);
    draw_line(2, 4, 1, 0, 24'h000000, 0);
    draw_line(2, 2, 0, 2, 24'hA5A5A5, 0);
    draw_line(0, 2, 2, 0, 24'h5A5A5A, 0);
  endtask

  // Short lines at the corners of the coordinate range.
  task automatic test_coordinate_extremes();
    draw_line(-32768, -32768, -32767, -32768, 24'h800001, 0);
    draw_line(32767, 32767, 32766, 32765, 24'h7FFFFE, 0);
  endtask

  // Clipping and index wrap under tiny, empty, exact and oversized frames.
  task automatic test_frame_settings();
    draw_line(1998, 1498, 2001, 1500, 24'h00FF00, 0);
    set_frame(dim_t'(1), dim_t'(1));
    draw_line(-1, -1, 1, 1, 24'h0000FF, 0);
    set_frame(dim_t'(0), dim_t'(0));
    draw_line(0, 0, 1, 0, 24'hFF0000, 0);
    set_frame(dim_t'(4096), dim_t'(4096));
    draw_line(4094, 4095, 4096, 4095, 24'h010203, 0);
    set_frame(DimMax, DimMax);
    draw_line(8190, 8190, 8188, 8189, 24'hFEDCBA, 0);
  endtask

  // Two lines across the whole coordinate range reach the widest error values
  // in their first steps; each is abandoned after a short walk.
  task automatic test_full_span_walks();
    set_frame(dim_t'(4096), dim_t'(4096));
    feed_calm  = 1'b1;
    drain_calm = 1'b1;
    send_command(FuncStart, coord_t'(-32768), coord_t'(-32767), coord_t'(32767),
                 coord_t'(32767), 24'hC0FFEE);
    repeat (FullSpanSteps) step_line();
    send_command(FuncStart, coord_t'(32767), coord_t'(-32768), coord_t'(-32767),
                 coord_t'(32767), 24'h0BADF0);
    repeat (FullSpanSteps) step_line();
    drain_pipeline();
    feed_calm  = 1'b0;
    drain_calm = 1'b0;
  endtask

  // Random lines in batches, each batch under its own frame size and idling.
  task automatic test_random_lines();
    int first;
    int batch_end;
    int r;
    int reach;
    int x0;
    int y0;
    int x1;
    int y1;
    first = commands_sent;
    while (commands_sent - first < RandomItems) begin
      case ($urandom_range(0, 4))
        0: set_frame(dim_t'($urandom_range(1, 48)), dim_t'($urandom_range(1, 48)));
        1: set_frame(dim_t'($urandom_range(1, 4096)), dim_t'($urandom_range(1, 4096)));
        2: set_frame($urandom_range(0, 1) ? DimMax : dim_t'(0),
                     $urandom_range(0, 1) ? DimMax : dim_t'(0));
        3: set_frame(FrameWidthRst, FrameHeightRst);
        default: set_frame(dim_t'($urandom_range(1, 300)), dim_t'($urandom_range(1, 300)));
      endcase
      feed_calm  = ($urandom_range(0, 3) == 0);
      drain_calm = ($urandom_range(0, 3) == 0);
      batch_end  = commands_sent + BatchItems;
      while (commands_sent < batch_end) begin
        r = int'($urandom_range(0, 99));
        if (r < 70) begin
          // Short line around the frame edges.
          reach = ($urandom_range(0, 2) == 0) ? 3 : 16;
          x0    = int'($urandom_range(0, int'(fb_width) + 16)) - 8;
          y0    = int'($urandom_range(0, int'(fb_height) + 16)) - 8;
          x1    = x0 + int'($urandom_range(0, 2 * reach)) - reach;
          y1    = y0 + int'($urandom_range(0, 2 * reach)) - reach;
          draw_line(x0, y0, x1, y1, color_t'($urandom), ($urandom_range(0, 4) == 0));
        end else if (r < 82) begin
          // Arbitrary line, abandoned after a few pixels.
          send_command(FuncStart, coord_t'($urandom), coord_t'($urandom),
                       coord_t'($urandom), coord_t'($urandom), color_t'($urandom));
          repeat ($urandom_range(0, 6)) step_line();
        end else if (r < 92) begin
          // Short line hugging the ends of the coordinate range.
          x0 = $urandom_range(0, 1) ? 32767 : -32768;
          y0 = $urandom_range(0, 1) ? 32767 : -32768;
          x1 = (x0 > 0) ? x0 - int'($urandom_range(0, 12)) : x0 + int'($urandom_range(0, 12));
          y1 = (y0 > 0) ? y0 - int'($urandom_range(0, 12)) : y0 + int'($urandom_range(0, 12));
          draw_line(x0, y0, x1, y1, color_t'($urandom), ($urandom_range(0, 3) == 0));
        end else begin
          // Stray steps, sometimes after a zero-length line.
          if ($urandom_range(0, 1) == 1) begin
            x0 = int'($signed(coord_t'($urandom)));
            y0 = int'($signed(coord_t'($urandom)));
            draw_line(x0, y0, x0, y0, color_t'($urandom), 0);
          end
          repeat ($urandom_range(1, 3)) step_line();
        end
      end
    end
    drain_pipeline();
  endtask

  // Result receiver: random back-pressure and a check of every transaction.
  initial begin : pixel_sink
    int     hold;
    pixel_t got;
    hold = 0;
    pix_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (pix_if.valid && pix_if.ready) begin
        got.pixel_valid = pix_if.pixel_valid;
        got.pixel_x     = pix_if.pixel_x;
        got.pixel_y     = pix_if.pixel_y;
        got.in_frame    = pix_if.in_frame;
        got.pixel_index = pix_if.pixel_index;
        got.pixel_color = pix_if.pixel_color;
        got.last        = pix_if.last;
        check_pixel(got);
        hold = idle_cycles(drain_calm);
      end
      if (hold > 0) begin
        pix_if.ready <= 1'b0;
        hold--;
      end else begin
        pix_if.ready <= 1'b1;
      end
    end
  end

  // End the run when no transaction moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if (!rst_n || (cmd_if.valid && cmd_if.ready) || (pix_if.valid && pix_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_bresenham_line_clipped_unit NOT OK");
    $finish;
  end

  // Reset, then the tests in turn, then the verdict.
  initial begin : stimulus
    rst_n             <= 1'b0;
    cmd_if.valid      <= 1'b0;
    cmd_if.func       <= FuncStart;
    cmd_if.start_x    <= '0;
    cmd_if.start_y    <= '0;
    cmd_if.end_x      <= '0;
    cmd_if.end_y      <= '0;
    cmd_if.line_color <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= RegFrameWidth;
    cfg_if.data       <= '0;
    fb_width          = FrameWidthRst;
    fb_height         = FrameHeightRst;
    walk_x            = '0;
    walk_y            = '0;
    goal_x            = '0;
    goal_y            = '0;
    dir_x             = StepZero;
    dir_y             = StepZero;
    dist_x            = '0;
    dist_y            = '0;
    err_sum           = '0;
    along_x           = 1'b0;
    ink               = '0;
    drawing           = 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_steps_without_line();
    test_line_directions();
    test_coordinate_extremes();
    test_frame_settings();
    test_full_span_walks();
    test_random_lines();
    drain_pipeline();

    $display("Sent %0d commands, checked %0d line pixels, made %0d frame register writes.",
             commands_sent, pixels_seen, cfg_writes);
    $display("Covered idle steps, all line directions, range and frame extremes, %s",
             "full-span starts and random lines.");
    if (mismatches == 0) begin
      $display("tb_bresenham_line_clipped_unit OK");
    end else begin
      $display("tb_bresenham_line_clipped_unit NOT OK");
    end
    $finish;
  end

endmodule
